>>> src/lsfc_pkg.sv
// Shared types and constants for the LED strip frame chunker.
// Used by lsfc_emit and led_strip_frame_chunker; depends on nothing.
package lsfc_pkg;

   // Word counts within one chunk; covers chunk sizes up to 64 words.
   localparam int unsigned CNT_W = 7;

   localparam logic [7:0]  LED_MARK  = 8'hE0;
   localparam logic [16:0] SENT_MAX  = 17'h1FFFF;
   localparam logic [17:0] STOP_ROUND = 18'd63;
   localparam int unsigned STOP_SHIFT = 6;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_STOPS = 4'b0010,
      ST_PLAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Layout of one chunk, handed from the planner to the word emitter.
   typedef struct packed {
      logic             do_start;
      logic [CNT_W-1:0] data_end;   // index past the last LED word
      logic [CNT_W-1:0] total;      // zero means an empty chunk
      logic [31:0]      data;
      logic             status;
   } plan_type;

endpackage

>>> src/lsfc_emit.sv
// Word emitter: steps through one chunk a word per cycle into the output register unless rsp_stall holds it.
// Depends on lsfc_pkg.
module lsfc_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              plan_start,
   input  lsfc_pkg::plan_type plan,
   output logic              busy,
   output logic              done,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_word,
   output logic              rsp_word_valid,
   output logic              rsp_last,
   output logic              rsp_status
);
   import lsfc_pkg::*;

   logic             active_ff, active_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   plan_type         plan_ff, plan_in;
   logic             valid_ff, valid_in;
   logic [31:0]      word_ff, word_in;
   logic             wvalid_ff, wvalid_in;
   logic             last_ff, last_in;
   logic             status_ff, status_in;

   logic             slot_free;
   logic             fire;
   logic             is_last;
   logic [CNT_W-1:0] idx_next;

   assign slot_free = !valid_ff || !rsp_stall;
   assign fire      = active_ff && slot_free;
   assign idx_next  = idx_ff + CNT_W'(1);
   assign is_last   = (plan_ff.total == '0) || (idx_next == plan_ff.total);
   assign done      = fire && is_last;
   assign busy      = active_ff;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      plan_in   = plan_ff;
      valid_in  = valid_ff;
      word_in   = word_ff;
      wvalid_in = wvalid_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (plan_start) begin
         active_in = 1'b1;
         idx_in    = '0;
         plan_in   = plan;
      end else if (fire) begin
         idx_in    = idx_next;
         valid_in  = 1'b1;
         wvalid_in = (plan_ff.total != '0);
         last_in   = is_last;
         status_in = plan_ff.status;
         // start frame first, then LED words, then stop words
         priority if (plan_ff.do_start && idx_ff == '0) begin
            word_in = '0;
         end else if (idx_ff < plan_ff.data_end) begin
            word_in = plan_ff.data;
         end else begin
            word_in = '0;
         end
         if (plan_ff.total == '0) begin
            word_in = '0;
         end
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      idx_ff    <= idx_in;
      plan_ff   <= plan_in;
      word_ff   <= word_in;
      wvalid_ff <= wvalid_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_word       = word_ff;
   assign rsp_word_valid = wvalid_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      plan_start |-> !active_ff)
      else $error("chunk started while emitter busy");

   assert property (@(posedge clock) disable iff (reset)
      fire |=> valid_ff)
      else $error("emitted word did not reach output register");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(word_ff) && $stable(last_ff)))
      else $error("stalled response changed");

endmodule

>>> src/led_strip_frame_chunker.sv
// LED strip frame chunker top level: command register, chunk planner and sequencer.
// Depends on lsfc_pkg and lsfc_emit.
//
// Usage:
//   A set-colour request (req_red/green/blue, req_brightness, req_led_count,
//   req_more_follows) is taken when req_valid is high and req_stall is low.
//   Each request yields a chunk of 1 to CHUNK_WORDS responses on the rsp_
//   channel: an optional zero start frame, LED words, then zero stop words.
//   rsp_last marks the final response of the chunk; rsp_status is 1 when the
//   strip frame is not finished and the command must be repeated. A chunk
//   with no words gives one response with rsp_word_valid low.
//   Timing: the ST_STOPS and ST_PLAN states plan the chunk after the request,
//   then one word per cycle goes through a single word sequencer when the
//   receiver never stalls. req_stall is high from acceptance until the last
//   response has been loaded into the output register; the next request may
//   be taken while it still waits.
//   rsp_stall freezes the output register and the sequencer with it.
//   Reset (synchronous): no chunk in flight, a start frame is pending, no
//   leftover LEDs and the sent count is zero.
module led_strip_frame_chunker #(
   parameter int unsigned CHUNK_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_brightness,
   input  logic [15:0] req_led_count,
   input  logic        req_more_follows,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_word,
   output logic        rsp_word_valid,
   output logic        rsp_last,
   output logic        rsp_status
);
   import lsfc_pkg::*;

   localparam logic [CNT_W-1:0] SPACE_FULL = CNT_W'(CHUNK_WORDS);
   localparam logic [CNT_W-1:0] STOP_CAP   = CNT_W'(CHUNK_WORDS - 1);

   state_type        state_ff, state_in;
   logic             start_pending_ff, start_pending_in;
   logic [15:0]      remaining_ff, remaining_in;
   logic [16:0]      sent_ff, sent_in;

   logic [31:0]      data_ff, data_in;
   logic [15:0]      count_ff, count_in;
   logic             follows_ff, follows_in;
   logic             noop_ff, noop_in;
   logic [CNT_W-1:0] stops_ff, stops_in;

   logic             accept;
   logic [15:0]      cnt_eff;
   logic [16:0]      sent_eff;
   logic [17:0]      stop_sum;
   logic [11:0]      stop_q;

   logic [CNT_W-1:0] space;
   logic             fits;
   logic [15:0]      cnt_m1;
   logic [CNT_W-1:0] chunk;
   logic [CNT_W-1:0] stops_use;
   logic [17:0]      sent_sum;
   logic [15:0]      rem_new;

   plan_type         plan;
   logic             plan_start;
   logic             emit_busy;
   logic             emit_done;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Stop word count: ceil((count + sent) / 64), capped
   assign cnt_eff  = (remaining_ff != '0) ? remaining_ff : count_ff;
   assign sent_eff = start_pending_ff ? '0 : sent_ff;
   assign stop_sum = {2'b00, cnt_eff} + {1'b0, sent_eff} + STOP_ROUND;
   assign stop_q   = stop_sum[17:STOP_SHIFT];

   // Chunk fit against the space left after an optional start frame
   assign space     = SPACE_FULL - CNT_W'(start_pending_ff);
   assign fits      = ({1'b0, count_ff} + {10'b0, stops_ff}) <= {10'b0, space};
   assign cnt_m1    = count_ff - 16'd1;
   assign stops_use = fits ? stops_ff : '0;
   always_comb begin
      priority if (fits) begin
         chunk = count_ff[CNT_W-1:0];
      end else if (cnt_m1 < {9'b0, space}) begin
         chunk = cnt_m1[CNT_W-1:0];
      end else begin
         chunk = space;
      end
   end
   assign rem_new  = count_ff - {9'b0, chunk};
   assign sent_sum = {1'b0, sent_eff} + {11'b0, chunk};

   always_comb begin
      state_in         = state_ff;
      start_pending_in = start_pending_ff;
      remaining_in     = remaining_ff;
      sent_in          = sent_ff;
      data_in          = data_ff;
      count_in         = count_ff;
      follows_in       = follows_ff;
      noop_in          = noop_ff;
      stops_in         = stops_ff;
      plan_start       = 1'b0;
      plan             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in    = {req_red, req_green, req_blue,
                             LED_MARK | {3'b000, req_brightness[7:3]}};
               count_in   = req_led_count;
               follows_in = req_more_follows;
               state_in   = ST_STOPS;
            end
         end
         ST_STOPS: begin
            // idle command tests the new count, before any leftover override
            noop_in  = (count_ff == '0) && !start_pending_ff && !follows_ff;
            count_in = cnt_eff;
            if (follows_ff) begin
               stops_in = '0;
            end else if (stop_q > {5'b0, STOP_CAP}) begin
               stops_in = STOP_CAP;
            end else begin
               stops_in = stop_q[CNT_W-1:0];
            end
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            plan_start = 1'b1;
            plan.data  = data_ff;
            if (!noop_ff) begin
               plan.do_start    = start_pending_ff;
               plan.data_end    = CNT_W'(start_pending_ff) + chunk;
               plan.total       = CNT_W'(start_pending_ff) + chunk + stops_use;
               plan.status      = (rem_new != '0);
               remaining_in     = rem_new;
               sent_in          = sent_sum[17] ? SENT_MAX : sent_sum[16:0];
               start_pending_in = (rem_new == '0) && !follows_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         start_pending_ff <= 1'b1;
         remaining_ff     <= '0;
         sent_ff          <= '0;
      end else begin
         state_ff         <= state_in;
         start_pending_ff <= start_pending_in;
         remaining_ff     <= remaining_in;
         sent_ff          <= sent_in;
      end
      data_ff    <= data_in;
      count_ff   <= count_in;
      follows_ff <= follows_in;
      noop_ff    <= noop_in;
      stops_ff   <= stops_in;
   end

   lsfc_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .plan_start     (plan_start),
      .plan           (plan),
      .busy           (emit_busy),
      .done           (emit_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .rsp_word_valid (rsp_word_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

   assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> req_stall)
      else $error("request taken while chunk in flight");

   assert property (@(posedge clock) disable iff (reset)
      (remaining_ff != '0) |-> !start_pending_ff)
      else $error("start frame pending with leftover LEDs");

   assert property (@(posedge clock) disable iff (reset)
      emit_done |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after last word");

   assert property (@(posedge clock) disable iff (reset)
      plan_start |=> emit_busy)
      else $error("planned chunk not picked up");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for led_strip_frame_chunker.
// Needs lsfc_pkg and the chunker RTL; a scoreboard class predicts every LED word.
`timescale 1ns / 100ps

module testbench;
   import lsfc_pkg::*;

   localparam int CHUNK = 64;
   localparam int LIMIT = 3_000_000;
   localparam int PHASE_ITEMS = 125;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 80;
   localparam int unsigned SENT_CAP = 131071;

   typedef struct {
      logic [31:0] word;
      logic        word_valid;
      logic        last;
      logic        status;
   } led_word_type;

   class chunk_tracker;
      led_word_type pending[$];
      bit          start_due;
      int unsigned leds_owed;
      int unsigned sent_leds;
      int unsigned faults;

      function new();
         start_due = 1'b1;
         leds_owed = 0;
         sent_leds = 0;
         faults = 0;
      endfunction

      function void push_word(logic [31:0] word, logic wv, logic last, logic status);
         led_word_type w;
         w.word = word;
         w.word_valid = wv;
         w.last = last;
         w.status = status;
         pending.push_back(w);
      endfunction

      // Predicts the chunk for one accepted request and queues its words.
      function void add_command(input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue, input logic [7:0] brightness,
                                input logic [15:0] count_in, input bit follows);
         int unsigned count, space, stops, chunk, total, n;
         logic [31:0] led_word, word;
         bit with_start;
         logic st;
         count = 32'(count_in);
         space = CHUNK;
         if (count == 0 && !start_due && !follows) begin
            push_word(32'h0, 1'b0, 1'b1, 1'b0);
            return;
         end
         if (leds_owed != 0)
            count = leds_owed;
         led_word = {red, green, blue, LED_MARK | {3'b000, brightness[7:3]}};
         with_start = start_due;
         if (with_start) begin
            space = space - 1;
            sent_leds = 0;
         end
         if (follows)
            stops = 0;
         else begin
            stops = (count + sent_leds + 63) / 64;
            if (stops > CHUNK - 1)
               stops = CHUNK - 1;
         end
         // overflow: hold back at least one LED so the next request carries the stops
         if (count + stops <= space)
            chunk = count;
         else begin
            chunk = (count - 1 < space) ? count - 1 : space;
            stops = 0;
         end
         leds_owed = (count - chunk) & 16'hFFFF;
         sent_leds = sent_leds + chunk;
         if (sent_leds > SENT_CAP)
            sent_leds = SENT_CAP;
         start_due = (leds_owed == 0 && !follows);
         st = (leds_owed != 0);
         total = with_start + chunk + stops;
         if (total == 0) begin
            push_word(32'h0, 1'b0, 1'b1, st);
            return;
         end
         for (n = 0; n < total; n++) begin
            if (with_start && n == 0)
               word = 32'h0;
            else if (n < with_start + chunk)
               word = led_word;
            else
               word = 32'h0;
            push_word(word, 1'b1, n == total - 1, st);
         end
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         faults++;
         if (faults <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void check_word(input logic [31:0] word, input logic wv,
                               input logic last, input logic status);
         led_word_type w;
         if (pending.size() == 0) begin
            faults++;
            if (faults <= 40)
               $display("%0t: response with nothing expected, word %0h", $time, word);
            return;
         end
         w = pending.pop_front();
         if (word !== w.word)
            report("rsp_word", w.word, word);
         if (wv !== w.word_valid)
            report("rsp_word_valid", 32'(w.word_valid), 32'(wv));
         if (last !== w.last)
            report("rsp_last", 32'(w.last), 32'(last));
         if (status !== w.status)
            report("rsp_status", 32'(w.status), 32'(status));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = 8'h0;
   logic [7:0]  req_green = 8'h0;
   logic [7:0]  req_blue = 8'h0;
   logic [7:0]  req_brightness = 8'h0;
   logic [15:0] req_led_count = 16'h0;
   logic        req_more_follows = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_word;
   logic        rsp_word_valid;
   logic        rsp_last;
   logic        rsp_status;

   chunk_tracker tracker = new();
   int          cycles = 0;
   int          items_sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;

   led_strip_frame_chunker #(.CHUNK_WORDS(CHUNK)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_brightness(req_brightness),
      .req_led_count(req_led_count),
      .req_more_follows(req_more_follows),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .rsp_word_valid(rsp_word_valid),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      while (cycles < LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // Response side: checks accepted words and drives rsp_stall.
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.check_word(rsp_word, rsp_word_valid, rsp_last, rsp_status);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task send_command(input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
                     input logic [7:0] brightness, input logic [15:0] count, input bit follows);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= red;
      req_green <= green;
      req_blue <= blue;
      req_brightness <= brightness;
      req_led_count <= count;
      req_more_follows <= follows;
      do @(posedge clock); while (req_stall);
      tracker.add_command(red, green, blue, brightness, count, follows);
      items_sent++;
   endtask

   // Repeats a request while the chunker still owes LEDs from a split.
   task send_until_done(input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
                        input logic [7:0] brightness, input logic [15:0] count,
                        input bit follows);
      send_command(red, green, blue, brightness, count, follows);
      while (tracker.leds_owed != 0)
         send_command(red, green, blue, brightness, count, follows);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending.size() != 0);
   endtask

   function automatic logic [15:0] pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25)
         return 16'($urandom_range(4));
      if (r < 60)
         return 16'($urandom_range(70, 5));
      if (r < 90)
         return 16'($urandom_range(300, 71));
      if (r < 99)
         return 16'($urandom_range(1500, 301));
      return 16'($urandom_range(65535));
   endfunction

   // One strip frame: a few requests that continue each other, each repeated
   // until its LEDs are all sent; some noise breaks the pattern.
   task run_frame(input int goal);
      int unsigned parts, k;
      logic [7:0]  r, g, b, br;
      logic [15:0] cnt;
      bit          fol;
      parts = $urandom_range(4, 1);
      for (k = 0; k < parts && items_sent < goal; k++) begin
         r = 8'($urandom_range(255));
         g = 8'($urandom_range(255));
         b = 8'($urandom_range(255));
         br = 8'($urandom_range(255));
         cnt = pick_count();
         fol = (k + 1 < parts);
         if ($urandom_range(99) < 12)
            fol = 1'($urandom_range(1));
         send_command(r, g, b, br, cnt, fol);
         while (tracker.leds_owed != 0 && items_sent < goal) begin
            if ($urandom_range(99) < 10) begin
               r = 8'($urandom_range(255));
               br = 8'($urandom_range(255));
               cnt = 16'($urandom_range(3));
               fol = 1'($urandom_range(1));
            end
            send_command(r, g, b, br, cnt, fol);
         end
      end
   endtask

   task random_part(input int n);
      int goal;
      goal = items_sent + n;
      while (items_sent < goal)
         run_frame(goal);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 76;

      // start frame alone, then full-scale colors
      send_command(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0);
      send_command(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd1, 1'b0);
      send_command(8'hAA, 8'h55, 8'hAA, 8'h55, 16'd3, 1'b1);
      // nothing to do, then an empty chunk inside a continued frame
      send_command(8'h55, 8'hAA, 8'h55, 8'hAA, 16'd0, 1'b0);
      send_command(8'h12, 8'h34, 8'h56, 8'h07, 16'd0, 1'b1);
      // split chunk; a zero count with LEDs owed must not touch the state
      send_command(8'h01, 8'h02, 8'h03, 8'hF8, 16'd100, 1'b1);
      send_command(8'h04, 8'h05, 8'h06, 8'h08, 16'd0, 1'b0);
      send_command(8'h07, 8'h08, 8'h09, 8'h10, 16'd5, 1'b0);
      send_until_done(8'h80, 8'h40, 8'h20, 8'h7F, 16'd63, 1'b0);
      send_until_done(8'h11, 8'h22, 8'h33, 8'h44, 16'd64, 1'b0);
      send_until_done(8'h0F, 8'hF0, 8'h3C, 8'hC3, 16'd62, 1'b0);
      // long continued frame, then a single LED: stop words hit their cap
      send_until_done(8'hFF, 8'h00, 8'hFF, 8'h00, 16'd4100, 1'b1);
      send_command(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd1, 1'b0);
      send_command(8'h9A, 8'hBC, 8'hDE, 8'h18, 16'd0, 1'b1);
      send_command(8'h9A, 8'hBC, 8'hDE, 8'h18, 16'd0, 1'b0);

      // receiver holds off while requests keep coming
      hold_requests++;
      random_part(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 76;
      recv_idle_pct = 17;
      random_part(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_part(PHASE_ITEMS);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.faults == 0 && tracker.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
